// ===== rtl/wbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wbsp_pkg
// Shared types and constants for the window block stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wbsp_pkg;

	// parse phase, equal to the field kind of the field in progress
	typedef enum logic [2:0] {
		PH_LENGTH    = 3'd0,
		PH_MODEL     = 3'd1,
		PH_ENCODING  = 3'd2,
		PH_PRECISION = 3'd3,
		PH_PARAM     = 3'd4,
		PH_RESCOUNT  = 3'd5,
		PH_RESIDUAL  = 3'd6
	} phase_t;

	typedef enum logic {
		ERR_BAD_MODEL = 1'b0,
		ERR_TRUNCATED = 1'b1
	} err_code_t;

	localparam logic [7:0] NUM_MODELS    = 8'd6;
	localparam logic [2:0] LAST_BYTE_W32 = 3'd3;
	localparam logic [2:0] LAST_BYTE_W64 = 3'd7;

	typedef struct packed {
		logic [2:0]  field_kind;
		logic [63:0] field_value;
		logic [1:0]  param_index;
		logic        block_done;
		logic [32:0] block_length;
		logic        error_flag;
		logic        error_code;
	} result_t;

	// number of 64-bit parameters that follow the header for a known model
	function automatic logic [2:0] param_count(input logic [2:0] model);
		logic [2:0] cnt;
		case (model)
			3'd0: cnt = 3'd2;
			3'd1: cnt = 3'd3;
			3'd2: cnt = 3'd1;
			3'd3: cnt = 3'd1;
			3'd4: cnt = 3'd4;
			3'd5: cnt = 3'd2;
			default: cnt = 3'd0;
		endcase
		return cnt;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/window_block_stream_parser.sv =====
// ----------------------------------------------------------------------------
// window_block_stream_parser
// Byte-serial parser for a stream of window blocks, one field per result.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready) takes one stream byte per
//   transaction, with end_of_data marking the last byte of a buffer.
//   result channel (result_valid/result_ready) gives at most one result per
//   byte: each completed field, each residual byte, a block_done result with
//   the block length, or an error result.
//   Each byte is parsed in the cycle it is accepted; its result is registered
//   in the output or skid register. One byte per cycle is sustained while
//   result_ready stays high; the figure is set by the single state update per
//   byte plus the two-entry result buffer (output register and skid register).
//   While the receiver stalls, bytes are still accepted until the skid
//   register also holds a result; then item_ready drops.
//   Reset clears the parse state to the start of a block and empties the
//   result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module window_block_stream_parser import wbsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_data,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [2:0]       field_kind,
	output logic [63:0]      field_value,
	output logic [1:0]       param_index,
	output logic             block_done,
	output logic [32:0]      block_length,
	output logic             error_flag,
	output logic             error_code
);

	phase_t      phase_q, phase_nxt;
	logic [2:0]  bif_q, bif_nxt;
	logic [63:0] acc_q, acc_nxt, acc_sum;
	logic [2:0]  params_left_q, params_left_nxt;
	logic [1:0]  param_cnt_q, param_cnt_nxt;
	logic [31:0] res_left_q, res_left_nxt, res_dec;
	logic [32:0] bytes_q, bytes_nxt, bytes_inc;
	logic        dropping_q, dropping_nxt;
	logic [2:0]  params_dec;

	logic        complete, done, bad_model, has_res;
	logic [63:0] value;
	result_t     res;

	logic        out_v_q, skid_v_q;
	result_t     out_q, skid_q;
	logic        item_fire, push, pop;

	assign item_ready = !skid_v_q;
	assign item_fire  = item_valid && item_ready;
	assign push       = item_fire && has_res;
	assign pop        = out_v_q && result_ready;

	assign acc_sum    = acc_q | ({56'd0, data_byte} << {bif_q, 3'b000});
	assign bytes_inc  = bytes_q + 33'd1;
	assign params_dec = params_left_q - 3'd1;
	assign res_dec    = res_left_q - 32'd1;

	always_comb begin
		phase_nxt       = phase_q;
		bif_nxt         = bif_q;
		acc_nxt         = acc_q;
		params_left_nxt = params_left_q;
		param_cnt_nxt   = param_cnt_q;
		res_left_nxt    = res_left_q;
		bytes_nxt       = bytes_q;
		dropping_nxt    = dropping_q;
		complete        = 1'b0;
		done            = 1'b0;
		bad_model       = 1'b0;
		has_res         = 1'b0;
		value           = '0;
		res             = '0;

		if (dropping_q) begin
			if (end_of_data) begin
				phase_nxt       = PH_LENGTH;
				bif_nxt         = '0;
				acc_nxt         = '0;
				params_left_nxt = '0;
				param_cnt_nxt   = '0;
				res_left_nxt    = '0;
				bytes_nxt       = '0;
				dropping_nxt    = 1'b0;
			end
		end else begin
			bytes_nxt = bytes_inc;
			case (phase_q)
				PH_LENGTH, PH_RESCOUNT: begin
					acc_nxt  = acc_sum;
					bif_nxt  = bif_q + 3'd1;
					complete = (bif_q == LAST_BYTE_W32);
				end
				PH_PARAM: begin
					acc_nxt  = acc_sum;
					bif_nxt  = bif_q + 3'd1;
					complete = (bif_q == LAST_BYTE_W64);
				end
				default: begin
					acc_nxt  = {56'd0, data_byte};
					complete = 1'b1;
				end
			endcase

			if (complete) begin
				value   = acc_nxt;
				acc_nxt = '0;
				bif_nxt = '0;
				case (phase_q)
					PH_LENGTH: phase_nxt = PH_MODEL;
					PH_MODEL: begin
						if (data_byte >= NUM_MODELS) begin
							bad_model = 1'b1;
						end else begin
							params_left_nxt = param_count(data_byte[2:0]);
							param_cnt_nxt   = '0;
							phase_nxt       = PH_ENCODING;
						end
					end
					PH_ENCODING:  phase_nxt = PH_PRECISION;
					PH_PRECISION: phase_nxt = PH_PARAM;
					PH_PARAM: begin
						param_cnt_nxt   = param_cnt_q + 2'd1;
						params_left_nxt = params_dec;
						if (params_dec == 3'd0) begin
							phase_nxt = PH_RESCOUNT;
						end
					end
					PH_RESCOUNT: begin
						res_left_nxt = value[31:0];
						if (value[31:0] == 32'd0) begin
							done = 1'b1;
						end else begin
							phase_nxt = PH_RESIDUAL;
						end
					end
					default: begin
						res_left_nxt = res_dec;
						done         = (res_dec == 32'd0);
					end
				endcase
			end

			res.field_kind = phase_q;
			if (bad_model) begin
				has_res        = 1'b1;
				res.field_kind = PH_MODEL;
				res.field_value = value;
				res.error_flag = 1'b1;
				res.error_code = ERR_BAD_MODEL;
			end else if (done) begin
				has_res          = 1'b1;
				res.field_value  = value;
				res.block_done   = 1'b1;
				res.block_length = bytes_inc;
			end else if (end_of_data) begin
				has_res        = 1'b1;
				res.error_flag = 1'b1;
				res.error_code = ERR_TRUNCATED;
			end else if (complete) begin
				has_res         = 1'b1;
				res.field_value = value;
				if (phase_q == PH_PARAM) begin
					res.param_index = param_cnt_q;
				end
			end

			// back to the start of a block after a finished block, an error or end of data
			if (bad_model || done || end_of_data) begin
				phase_nxt       = PH_LENGTH;
				bif_nxt         = '0;
				acc_nxt         = '0;
				params_left_nxt = '0;
				param_cnt_nxt   = '0;
				res_left_nxt    = '0;
				bytes_nxt       = '0;
				dropping_nxt    = bad_model && !end_of_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LENGTH;
			bif_q         <= '0;
			acc_q         <= '0;
			params_left_q <= '0;
			param_cnt_q   <= '0;
			res_left_q    <= '0;
			bytes_q       <= '0;
			dropping_q    <= 1'b0;
		end else if (item_fire) begin
			phase_q       <= phase_nxt;
			bif_q         <= bif_nxt;
			acc_q         <= acc_nxt;
			params_left_q <= params_left_nxt;
			param_cnt_q   <= param_cnt_nxt;
			res_left_q    <= res_left_nxt;
			bytes_q       <= bytes_nxt;
			dropping_q    <= dropping_nxt;
		end
	end

	// two-entry result buffer: output register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q) begin
				out_v_q <= push;
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || (pop && !skid_v_q)) begin
			out_q <= res;
		end else if (pop) begin
			out_q <= skid_q;
		end
		if (out_v_q && !pop && push) begin
			skid_q <= res;
		end
	end

	assign result_valid = out_v_q;
	assign field_kind   = out_q.field_kind;
	assign field_value  = out_q.field_value;
	assign param_index  = out_q.param_index;
	assign block_done   = out_q.block_done;
	assign block_length = out_q.block_length;
	assign error_flag   = out_q.error_flag;
	assign error_code   = out_q.error_code;

endmodule

`default_nettype wire
